>>> src/fpd_pkg.sv
// Shared constants, state type and arctangent table for the FSK phase discriminator.
`default_nettype none

package fpd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // threshold register width and angle accumulator width
  localparam int THR_W  = 17;
  localparam int ZW     = 18;
  localparam int TBL_IW = 5;

  localparam logic signed [ZW-1:0] Z_PI      = ZW'(32768);
  localparam logic signed [ZW-1:0] Z_HALF_PI = ZW'(16384);
  localparam logic signed [ZW-1:0] Z_TWO_PI  = ZW'(65536);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROT,
    ST_DONE
  } fpd_state_t;

  // atan(2^-k) scaled so that 32768 is pi, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_lut(input logic [TBL_IW-1:0] k);
    logic signed [ZW-1:0] t;
    case (k)
      5'd0:    t = ZW'(8192);
      5'd1:    t = ZW'(4836);
      5'd2:    t = ZW'(2555);
      5'd3:    t = ZW'(1297);
      5'd4:    t = ZW'(651);
      5'd5:    t = ZW'(326);
      5'd6:    t = ZW'(163);
      5'd7:    t = ZW'(81);
      5'd8:    t = ZW'(41);
      5'd9:    t = ZW'(20);
      5'd10:   t = ZW'(10);
      5'd11:   t = ZW'(5);
      5'd12:   t = ZW'(3);
      5'd13:   t = ZW'(1);
      5'd14:   t = ZW'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> src/fpd_serial_cmul.sv
// Bit-serial multiplier: current sample times the conjugate of the previous one.
`default_nettype none

module fpd_serial_cmul #(
  parameter int SAMPLE_WIDTH = fpd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [SAMPLE_WIDTH-1:0] cur_i,
  input  logic signed [SAMPLE_WIDTH-1:0] cur_q,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_i,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_q,
  output logic signed [2*SAMPLE_WIDTH:0] re,
  output logic signed [2*SAMPLE_WIDTH:0] im,
  output logic                           done
);
  import fpd_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int AW = 2 * SAMPLE_WIDTH + 1;
  localparam int CW = $clog2(SAMPLE_WIDTH);

  logic [W-1:0]          sh_i;
  logic [W-1:0]          sh_q;
  logic signed [W-1:0]   op_i;
  logic signed [W-1:0]   op_q;
  logic signed [AW-1:0]  acc_re;
  logic signed [AW-1:0]  acc_im;
  logic [CW-1:0]         cnt;
  logic                  busy;

  logic signed [AW-1:0]  pi_x;
  logic signed [AW-1:0]  pq_x;
  logic signed [AW-1:0]  term_re;
  logic signed [AW-1:0]  term_im;
  logic signed [AW-1:0]  re_next;
  logic signed [AW-1:0]  im_next;

  assign pi_x = AW'(op_i);
  assign pq_x = AW'(op_q);

  // one bit of I and Q each cycle, most significant first
  always_comb begin
    term_re = (sh_i[W-1] ? pi_x : '0) + (sh_q[W-1] ? pq_x : '0);
    term_im = (sh_q[W-1] ? pi_x : '0) - (sh_i[W-1] ? pq_x : '0);
    if (cnt == '0) begin
      // sign bit carries negative weight
      re_next = -term_re;
      im_next = -term_im;
    end else begin
      re_next = (acc_re <<< 1) + term_re;
      im_next = (acc_im <<< 1) + term_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_i <= cur_i;
      sh_q <= cur_q;
      op_i <= prev_i;
      op_q <= prev_q;
    end else if (busy) begin
      sh_i   <= {sh_i[W-2:0], 1'b0};
      sh_q   <= {sh_q[W-2:0], 1'b0};
      acc_re <= re_next;
      acc_im <= im_next;
    end
  end

  assign re = acc_re;
  assign im = acc_im;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while still busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt <= CW'(W - 1)))
    else $error("multiplier bit count out of range");
`endif

endmodule

`default_nettype wire

>>> src/fpd_cordic.sv
// Iterative vectoring CORDIC giving the angle of the product word.
`default_nettype none

module fpd_cordic #(
  parameter int SAMPLE_WIDTH = fpd_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = fpd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [2*SAMPLE_WIDTH:0]   re,
  input  logic signed [2*SAMPLE_WIDTH:0]   im,
  output logic signed [fpd_pkg::ZW-1:0]    angle,
  output logic                             done
);
  import fpd_pkg::*;

  localparam int XW = 2 * SAMPLE_WIDTH + 3;
  localparam int KW = $clog2(CORDIC_STEPS);

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [KW-1:0]        k;
  logic                 busy;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] re_x;
  logic signed [XW-1:0] im_x;
  logic signed [ZW-1:0] t;
  logic                 axis;

  assign re_x = XW'(re);
  assign im_x = XW'(im);
  assign xs   = x >>> k;
  assign ys   = y >>> k;
  assign t    = atan_lut(TBL_IW'(k));
  // zero product and axis vectors skip the iterations
  assign axis = (im == '0) || (re == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        k    <= '0;
        busy <= !axis;
        done <= axis;
      end else if (busy) begin
        k <= k + 1'b1;
        if (k == KW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (im == '0) begin
        z <= (re < 0) ? Z_PI : '0;
      end else if (re == '0) begin
        z <= (im > 0) ? Z_HALF_PI : -Z_HALF_PI;
      end else if (re < 0) begin
        // rotate the left half-plane by pi first
        x <= -re_x;
        y <= -im_x;
        z <= (im > 0) ? Z_PI : -Z_PI;
      end else begin
        x <= re_x;
        y <= im_x;
        z <= '0;
      end
    end else if (busy) begin
      if (y >= 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + t;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - t;
      end
    end
  end

  // fold back into (-pi, pi]
  always_comb begin
    if (z > Z_PI) begin
      angle = z - Z_TWO_PI;
    end else if (z <= -Z_PI) begin
      angle = z + Z_TWO_PI;
    end else begin
      angle = z;
    end
  end

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("rotator started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("rotator done while still busy");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (k <= KW'(CORDIC_STEPS - 1)))
    else $error("rotator step count out of range");
`endif

endmodule

`default_nettype wire

>>> src/fsk_phase_discriminator_unit.sv
// FSK quadrature discriminator: phase step per sample sliced against a threshold.
//
// Input channel: sample_i / sample_q with in_valid, in_stall. A word is taken
// when in_valid is high and in_stall low. Output channel: bit_out with
// out_valid, out_stall; one bit per sample, 1 when the phase step between this
// sample and the last is at or above threshold_angle (32768 = pi).
// Configuration: threshold_angle with cfg_valid, cfg_ready; cfg_ready is always
// high. Write only while no sample is in flight.
// Flow: a word is multiplied by the conjugate of the previous one, one bit per
// cycle, then rotated by the CORDIC, one step per cycle (skipped for zero or
// axis products), and its bit is then loaded into the output register. in_stall
// stays high from acceptance until that load, so the block takes no new sample
// before the bit of the last one is loaded; the serial multiplier and the
// single CORDIC stage set the pace.
// The output register lets the next sample be taken while a bit still waits;
// a stalled bit holds until taken, and the block then waits before overwriting.
// Reset (rst, synchronous): stored previous sample and threshold go to zero, so
// the first sample after reset gives a zero product and angle 0.
`default_nettype none

module fsk_phase_discriminator_unit #(
  parameter int SAMPLE_WIDTH = fpd_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = fpd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_q,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              bit_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic signed [fpd_pkg::THR_W-1:0]  threshold_angle
);
  import fpd_pkg::*;

  fpd_state_t state;
  fpd_state_t state_next;

  logic signed [SAMPLE_WIDTH-1:0] prev_i;
  logic signed [SAMPLE_WIDTH-1:0] prev_q;
  logic signed [THR_W-1:0]        thr;

  logic                           accept;
  logic                           mul_done;
  logic                           rot_done;
  logic                           out_load;
  logic signed [2*SAMPLE_WIDTH:0] prod_re;
  logic signed [2*SAMPLE_WIDTH:0] prod_im;
  logic signed [ZW-1:0]           angle;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  fpd_serial_cmul #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_cmul (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .cur_i (sample_i),
    .cur_q (sample_q),
    .prev_i(prev_i),
    .prev_q(prev_q),
    .re    (prod_re),
    .im    (prod_im),
    .done  (mul_done)
  );

  fpd_cordic #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(mul_done),
    .re   (prod_re),
    .im   (prod_im),
    .angle(angle),
    .done (rot_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) state_next = ST_ROT;
      end
      ST_ROT: begin
        if (rot_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // the multiplier latches the old sample on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_i <= '0;
      prev_q <= '0;
    end else if (accept) begin
      prev_i <= sample_i;
      prev_q <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr <= threshold_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bit_out <= (angle >= ZW'(thr));
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MUL))
    else $error("accepted word did not start the multiplier");
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_MUL))
    else $error("multiplier finished outside its phase");
  a_rot_done_state: assert property (@(posedge clk) disable iff (rst)
    rot_done |-> (state == ST_ROT))
    else $error("rotator finished outside its phase");
`endif

endmodule

`default_nettype wire

>>> verif/fsk_phase_discriminator_unit_tb.sv
// Self-checking testbench for the FSK phase discriminator: tone bursts, noise and axis cases.
module fsk_phase_discriminator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = fpd_pkg::SAMPLE_WIDTH_DEF;
  localparam int TW = fpd_pkg::THR_W;
  localparam int STEPS = fpd_pkg::CORDIC_STEPS_DEF;
  localparam longint ANGLE_PI = 32768;
  localparam real PI = 3.14159265358979323846;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 120;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [SW-1:0] i;
    logic signed [SW-1:0] q;
  } sample_word_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] sample_i = '0;
  logic signed [SW-1:0] sample_q = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic bit_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [TW-1:0] threshold_angle = '0;

  // predictor state
  logic signed [SW-1:0] last_i = '0;
  logic signed [SW-1:0] last_q = '0;
  logic signed [TW-1:0] thr_now = '0;

  sample_word_t pending_words[$];
  logic expected_bits[$];

  logic calm = 1'b0;
  int words_sent = 0;
  int bits_checked = 0;
  int mismatches = 0;
  int thr_writes = 0;

  fsk_phase_discriminator_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_i(sample_i),
    .sample_q(sample_q),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .bit_out(bit_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .threshold_angle(threshold_angle)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Phase step between this sample and the last, sliced against the threshold.
  function automatic logic slice_phase_step(input logic signed [SW-1:0] ci,
                                            input logic signed [SW-1:0] cq);
    longint re, im, x, y, z, xs, ys, t;
    re = longint'(ci) * longint'(last_i) + longint'(cq) * longint'(last_q);
    im = longint'(cq) * longint'(last_i) - longint'(ci) * longint'(last_q);
    last_i = ci;
    last_q = cq;
    if (im == 0) begin
      z = (re < 0) ? ANGLE_PI : 0;
    end else if (re == 0) begin
      z = (im > 0) ? ANGLE_PI / 2 : -(ANGLE_PI / 2);
    end else begin
      // fold the left half-plane onto the right one
      if (re < 0) begin
        x = -re;
        y = -im;
        z = (im > 0) ? ANGLE_PI : -ANGLE_PI;
      end else begin
        x = re;
        y = im;
        z = 0;
      end
      for (int k = 0; k < STEPS; k++) begin
        case (k)
          0: t = 8192;
          1: t = 4836;
          2: t = 2555;
          3: t = 1297;
          4: t = 651;
          5: t = 326;
          6: t = 163;
          7: t = 81;
          8: t = 41;
          9: t = 20;
          10: t = 10;
          11: t = 5;
          12: t = 3;
          13: t = 1;
          14: t = 1;
          default: t = 0;
        endcase
        xs = x >>> k;
        ys = y >>> k;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + t;
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - t;
        end
      end
      if (z > ANGLE_PI) z = z - 2 * ANGLE_PI;
      if (z <= -ANGLE_PI) z = z + 2 * ANGLE_PI;
    end
    return (z >= longint'(thr_now));
  endfunction

  // Sender: hold a stalled word, otherwise present the next one or idle.
  always @(posedge clk) begin
    sample_word_t w;
    logic present;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      present = in_valid;
      if (in_valid && !in_stall) begin
        expected_bits.push_back(slice_phase_step(sample_i, sample_q));
        words_sent++;
        present = 1'b0;
      end
      if (!present && pending_words.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
        w = pending_words.pop_front();
        sample_i <= w.i;
        sample_q <= w.q;
        present = 1'b1;
      end
      in_valid <= present;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 31);
    end
  end

  // Receiver: compare each taken word with the oldest expected bit.
  always @(posedge clk) begin
    logic want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected bit_out word %0b", bit_out);
      end else begin
        want = expected_bits.pop_front();
        bits_checked++;
        if (bit_out !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("bit_out mismatch on word %0d: expected %0b, actual %0b",
                     bits_checked, want, bit_out);
          end
        end
      end
    end
  end

  initial begin
    sample_word_t w;
    int thr_list [0:PHASES-1];
    int made, kind, run, dev, tone, centre;
    real ang, amp;
    thr_list = '{0, -32768, 32768, 16384, -16384, 65535, -65536, 0, 0, 0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    ang = 0.0;
    for (int p = 0; p < PHASES; p++) begin
      if (p >= 7) thr_list[p] = int'($urandom_range(65536)) - 32768;
      // block is idle here: write the threshold
      @(posedge clk);
      cfg_valid <= 1'b1;
      threshold_angle <= TW'(thr_list[p]);
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      thr_now = TW'(thr_list[p]);
      thr_writes++;
      calm = (p == 3);

      if (p == 0) begin
        // zero product after reset, the real and imaginary axes, near +/-pi
        w.i = 0;      w.q = 0;      pending_words.push_back(w);
        w.i = 1000;   w.q = 0;      pending_words.push_back(w);
        w.i = 1000;   w.q = 0;      pending_words.push_back(w);
        w.i = -1000;  w.q = 0;      pending_words.push_back(w);
        w.i = 0;      w.q = -1000;  pending_words.push_back(w);
        w.i = -1000;  w.q = 300;    pending_words.push_back(w);
        w.i = 1000;   w.q = 0;      pending_words.push_back(w);
        w.i = 0;      w.q = -1000;  pending_words.push_back(w);
        w.i = 1000;   w.q = 0;      pending_words.push_back(w);
        w.i = 0;      w.q = 1000;   pending_words.push_back(w);
        w.i = 1000;   w.q = 0;      pending_words.push_back(w);
        w.i = -1000;  w.q = -1;     pending_words.push_back(w);
        w.i = 1000;   w.q = 0;      pending_words.push_back(w);
        w.i = -1000;  w.q = 1;      pending_words.push_back(w);
        w.i = -32768; w.q = -32768; pending_words.push_back(w);
        w.i = 32767;  w.q = 32767;  pending_words.push_back(w);
        w.i = -32768; w.q = 32767;  pending_words.push_back(w);
        w.i = 32767;  w.q = -32768; pending_words.push_back(w);
        w.i = -32768; w.q = 0;      pending_words.push_back(w);
        w.i = 0;      w.q = -32768; pending_words.push_back(w);
        w.i = 0;      w.q = 0;      pending_words.push_back(w);
        w.i = 5;      w.q = 5;      pending_words.push_back(w);
      end

      centre = thr_list[p];
      if (centre > 32768) centre = 32768;
      if (centre < -32768) centre = -32768;
      made = 0;
      while (made < WORDS_PER_PHASE) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          // tone burst: mark and space symbols around the threshold
          run = $urandom_range(24, 6);
          amp = $urandom_range(32767, 64);
          dev = (kind < 20) ? $urandom_range(64, 1) : $urandom_range(6000, 1);
          tone = centre;
          for (int k = 0; k < run; k++) begin
            if (k % 4 == 0) tone = $urandom_range(1) ? centre + dev : centre - dev;
            ang = ang + tone * PI / 32768.0;
            w.i = SW'($rtoi(amp * $cos(ang)));
            w.q = SW'($rtoi(amp * $sin(ang)));
            pending_words.push_back(w);
            made++;
          end
        end else if (kind < 85) begin
          w.i = SW'($urandom);
          w.q = SW'($urandom);
          pending_words.push_back(w);
          made++;
        end else begin
          case ($urandom_range(3))
            0: begin w.i = SW'($urandom); w.q = 0; end
            1: begin w.i = 0; w.q = SW'($urandom); end
            2: begin w.i = 0; w.q = 0; end
            default: begin
              w.i = -32768;
              w.q = SW'($urandom_range(1) ? -32768 : 32767);
            end
          endcase
          pending_words.push_back(w);
          made++;
        end
      end
      // drain: queue no more words until every pending word is sent and every expected bit has come back
      while (pending_words.size() != 0 || in_valid || expected_bits.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
    calm = 1'b0;

    $display("%0d samples sent over %0d threshold settings (extremes and random)",
             words_sent, thr_writes);
    $display("%0d decided bits checked, %0d mismatches", bits_checked, mismatches);
    if (mismatches == 0 && expected_bits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d bits still expected", expected_bits.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> fsk_phase_discriminator_unit.f
src/fpd_pkg.sv
src/fpd_serial_cmul.sv
src/fpd_cordic.sv
src/fsk_phase_discriminator_unit.sv
verif/fsk_phase_discriminator_unit_tb.sv
